FILE: src/fbc_pkg.sv
// Shared types, constants and functions of the 64-bit Feistel block cipher.
package fbc_pkg;

	localparam int ROUND_COUNT    = 32;
	localparam int KEY_WORDS      = 8;
	localparam int KEY_IDX_W      = 3;
	localparam int REV_KEY_ROUNDS = 8;
	localparam int HALF_W         = 32;
	localparam int BLOCK_W        = 64;
	localparam int ROT_L          = 11;

	localparam logic [3:0] SBOX_TAB [0:7][0:15] = '{
		'{4'd4,  4'd10, 4'd9,  4'd2,  4'd13, 4'd8,  4'd0,  4'd14,
		  4'd6,  4'd11, 4'd1,  4'd11, 4'd7,  4'd15, 4'd5,  4'd3},
		'{4'd14, 4'd11, 4'd4,  4'd12, 4'd6,  4'd13, 4'd15, 4'd10,
		  4'd2,  4'd3,  4'd8,  4'd1,  4'd0,  4'd7,  4'd5,  4'd9},
		'{4'd5,  4'd8,  4'd1,  4'd13, 4'd10, 4'd3,  4'd4,  4'd2,
		  4'd14, 4'd15, 4'd12, 4'd7,  4'd6,  4'd0,  4'd9,  4'd11},
		'{4'd7,  4'd13, 4'd10, 4'd1,  4'd0,  4'd8,  4'd9,  4'd15,
		  4'd14, 4'd4,  4'd6,  4'd12, 4'd11, 4'd2,  4'd5,  4'd3},
		'{4'd6,  4'd12, 4'd7,  4'd1,  4'd5,  4'd15, 4'd13, 4'd8,
		  4'd4,  4'd10, 4'd9,  4'd14, 4'd0,  4'd3,  4'd11, 4'd2},
		'{4'd4,  4'd11, 4'd10, 4'd0,  4'd7,  4'd2,  4'd1,  4'd13,
		  4'd3,  4'd6,  4'd8,  4'd5,  4'd9,  4'd12, 4'd15, 4'd14},
		'{4'd13, 4'd11, 4'd4,  4'd1,  4'd3,  4'd15, 4'd5,  4'd9,
		  4'd0,  4'd10, 4'd14, 4'd7,  4'd6,  4'd8,  4'd2,  4'd12},
		'{4'd1,  4'd15, 4'd13, 4'd0,  4'd5,  4'd7,  4'd10, 4'd4,
		  4'd9,  4'd2,  4'd3,  4'd14, 4'd6,  4'd11, 4'd8,  4'd12}
	};

	typedef struct packed {
		logic              valid;
		logic              dec;
		logic [HALF_W-1:0] a;
		logic [HALF_W-1:0] b;
	} fbc_stage_t;

	function automatic logic [HALF_W-1:0] bitrev32(input logic [HALF_W-1:0] v);
		bitrev32 = {<<{v}};
	endfunction

	function automatic logic [HALF_W-1:0] sbox_layer(input logic [HALF_W-1:0] v);
		logic [HALF_W-1:0] r;
		r = '0;
		for (int n = 0; n < 8; n++) begin
			r[4*n +: 4] = SBOX_TAB[7-n][v[4*n +: 4]];
		end
		sbox_layer = r;
	endfunction

endpackage

FILE: src/feistel_block_cipher_64_top.sv
// Top level of the 64-bit Feistel block cipher: key registers, round pipeline, output stage.
// A word passes through the ROUND_COUNT registered round cells and then the output register to reach out_valid.
// Throughput: one word per cycle while in_stall is low, set by the chain of ROUND_COUNT registered round cells.
// The output register and skid stage let a new word enter while a result waits to be taken.
// Reset clears the key words to zero and empties every pipeline stage at once.
module feistel_block_cipher_64_top #(
	parameter int ROUND_COUNT = fbc_pkg::ROUND_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fbc_pkg::KEY_IDX_W-1:0] cfg_index,
	input  logic [fbc_pkg::HALF_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [fbc_pkg::BLOCK_W-1:0]   block_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [fbc_pkg::BLOCK_W-1:0]   block_out
);

	localparam int W = fbc_pkg::HALF_W;

	logic [W-1:0]        key_q [fbc_pkg::KEY_WORDS];
	fbc_pkg::fbc_stage_t stage [ROUND_COUNT+1];
	logic                en;
	logic                skid_full;
	logic [fbc_pkg::BLOCK_W-1:0] result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fbc_pkg::KEY_WORDS; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	assign en       = !skid_full;
	assign in_stall = skid_full;

	assign stage[0] = '{valid: in_valid, dec: func,
		a: fbc_pkg::bitrev32(block_in[fbc_pkg::BLOCK_W-1:W]),
		b: fbc_pkg::bitrev32(block_in[W-1:0])};

	for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
		localparam logic [fbc_pkg::KEY_IDX_W-1:0] FWD_IDX =
			fbc_pkg::KEY_IDX_W'(r % fbc_pkg::KEY_WORDS);
		localparam logic [fbc_pkg::KEY_IDX_W-1:0] REV_IDX =
			fbc_pkg::KEY_IDX_W'(fbc_pkg::KEY_WORDS - 1 - (r % fbc_pkg::KEY_WORDS));

		fbc_round_cell #(
			.ROUND       (r),
			.ROUND_COUNT (ROUND_COUNT)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.key_fwd (key_q[FWD_IDX]),
			.key_rev (key_q[REV_IDX]),
			.prev    (stage[r]),
			.next    (stage[r+1])
		);
	end

	assign result = {fbc_pkg::bitrev32(stage[ROUND_COUNT].a),
		fbc_pkg::bitrev32(stage[ROUND_COUNT].b)};

	fbc_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (stage[ROUND_COUNT].valid),
		.in_data   (result),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (block_out)
	);

endmodule

FILE: src/fbc_round_cell.sv
// One registered Feistel round of the cipher pipeline.
module fbc_round_cell #(
	parameter int ROUND       = 0,
	parameter int ROUND_COUNT = fbc_pkg::ROUND_COUNT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [fbc_pkg::HALF_W-1:0]  key_fwd,
	input  logic [fbc_pkg::HALF_W-1:0]  key_rev,
	input  fbc_pkg::fbc_stage_t         prev,
	output fbc_pkg::fbc_stage_t         next
);

	localparam bit USE_REV_ENC = (ROUND >= ROUND_COUNT - fbc_pkg::REV_KEY_ROUNDS);
	localparam bit USE_REV_DEC = (ROUND >= fbc_pkg::REV_KEY_ROUNDS);
	localparam bit LAST        = (ROUND == ROUND_COUNT - 1);
	localparam int W           = fbc_pkg::HALF_W;

	logic         valid_q;
	logic         dec_q;
	logic [W-1:0] a_q;
	logic [W-1:0] b_q;

	logic         use_rev;
	logic [W-1:0] key;
	logic [W-1:0] sum1;
	logic [W-1:0] sum2;
	logic [W-1:0] rot;
	logic [W-1:0] f;

	always_comb begin
		use_rev = prev.dec ? USE_REV_DEC : USE_REV_ENC;
		key     = use_rev ? key_rev : key_fwd;
		sum1    = fbc_pkg::bitrev32(key) + prev.a;
		sum2    = sum1 + fbc_pkg::sbox_layer(sum1);
		rot     = {sum2[W-1-fbc_pkg::ROT_L:0], sum2[W-1:W-fbc_pkg::ROT_L]};
		f       = rot ^ prev.b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_q <= prev.dec;
			if (LAST) begin
				a_q <= prev.a;
				b_q <= f;
			end else begin
				a_q <= f;
				b_q <= prev.a;
			end
		end
	end

	assign next = '{valid: valid_q, dec: dec_q, a: a_q, b: b_q};

endmodule

FILE: src/fbc_out_skid.sv
// Output register with a skid stage that decouples the pipeline from the output stall.
module fbc_out_skid (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic [fbc_pkg::BLOCK_W-1:0]  in_data,
	output logic                         full,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [fbc_pkg::BLOCK_W-1:0]  out_data
);

	logic                        out_valid_q;
	logic [fbc_pkg::BLOCK_W-1:0] out_data_q;
	logic                        skid_valid_q;
	logic [fbc_pkg::BLOCK_W-1:0] skid_data_q;
	logic                        take;
	logic                        load;

	assign take = out_valid_q && !out_stall;
	assign load = in_vld && !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (load) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
			end
		end else if (load) begin
			if (!out_valid_q || take) begin
				out_data_q <= in_data;
			end else begin
				skid_data_q <= in_data;
			end
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: src/fbc_checker.sv
// Port-level checker of the cipher top level and its bind statement.
module fbc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [fbc_pkg::BLOCK_W-1:0] block_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(block_out))
		else $error("Stalled output word changed or was dropped.");

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("Input stalled while no output word is waiting.");

	a_stall_clears: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |=> !in_stall)
		else $error("Input still stalled after the output was free.");

endmodule

bind feistel_block_cipher_64_top fbc_checker u_fbc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.block_out (block_out)
);
